@@ hdl/slbs_pkg.sv @@
package slbs_pkg;

    localparam int OFFSET_BITS_DEF   = 20;
    localparam int LINE_BITS_DEF     = 16;
    localparam int KEYWORD_CHARS_DEF = 6;

    localparam int START_W = 20;
    localparam int LEN_W   = 20;
    localparam int LINE_W  = 16;
    localparam int KIND_W  = 6;
    localparam int ERR_W   = 2;
    localparam int MAX_KW  = 6;

    localparam logic [KIND_W-1:0] K_LPAREN = 6'd0;
    localparam logic [KIND_W-1:0] K_RPAREN = 6'd1;
    localparam logic [KIND_W-1:0] K_LBRACE = 6'd2;
    localparam logic [KIND_W-1:0] K_RBRACE = 6'd3;
    localparam logic [KIND_W-1:0] K_COMMA  = 6'd4;
    localparam logic [KIND_W-1:0] K_DOT    = 6'd5;
    localparam logic [KIND_W-1:0] K_MINUS  = 6'd6;
    localparam logic [KIND_W-1:0] K_PLUS   = 6'd7;
    localparam logic [KIND_W-1:0] K_SEMI   = 6'd8;
    localparam logic [KIND_W-1:0] K_SLASH  = 6'd9;
    localparam logic [KIND_W-1:0] K_STAR   = 6'd10;
    localparam logic [KIND_W-1:0] K_BANG   = 6'd11;
    localparam logic [KIND_W-1:0] K_EQUAL  = 6'd13;
    localparam logic [KIND_W-1:0] K_GREATER = 6'd15;
    localparam logic [KIND_W-1:0] K_LESS   = 6'd17;
    localparam logic [KIND_W-1:0] K_IDENT  = 6'd19;
    localparam logic [KIND_W-1:0] K_STRING = 6'd20;
    localparam logic [KIND_W-1:0] K_NUMBER = 6'd21;
    localparam logic [KIND_W-1:0] K_ERROR  = 6'd38;
    localparam logic [KIND_W-1:0] K_EOF    = 6'd39;

    localparam logic [ERR_W-1:0] E_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] E_CHAR  = 2'd1;
    localparam logic [ERR_W-1:0] E_UNTERM = 2'd2;

    localparam logic [1:0] OP_BANG  = 2'd0;
    localparam logic [1:0] OP_EQUAL = 2'd1;
    localparam logic [1:0] OP_LESS  = 2'd2;
    localparam logic [1:0] OP_GREATER = 2'd3;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_SLASH,
        MODE_COMMENT,
        MODE_OP,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_NUMDOT,
        MODE_FRACTION,
        MODE_STRING
    } mode_t;

    typedef struct packed {
        logic               emit;
        logic [KIND_W-1:0]  kind;
        logic [ERR_W-1:0]   err;
        mode_t              mode;
        logic [1:0]         op;
        logic               bump;
        logic               word;
    } idle_t;

    function automatic int bundle_bits(input int ob, input int lb);
        return 2 + lb + 3 * (KIND_W + ob + ob + 1 + ERR_W);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [KIND_W-1:0] op_kind(input logic [1:0] op);
        logic [KIND_W-1:0] k;
        unique case (op)
            OP_BANG:    k = K_BANG;
            OP_EQUAL:   k = K_EQUAL;
            OP_LESS:    k = K_LESS;
            default:    k = K_GREATER;
        endcase
        return k;
    endfunction

    function automatic idle_t classify(input logic [7:0] c);
        idle_t r;
        r = '{emit: 1'b0, kind: K_ERROR, err: E_NONE, mode: MODE_IDLE,
              op: OP_BANG, bump: 1'b0, word: 1'b0};
        unique case (c)
            " ", 8'h0D, 8'h09: ;
            8'h0A: r.bump = 1'b1;
            "/": r.mode = MODE_SLASH;
            "(": begin r.emit = 1'b1; r.kind = K_LPAREN; end
            ")": begin r.emit = 1'b1; r.kind = K_RPAREN; end
            "{": begin r.emit = 1'b1; r.kind = K_LBRACE; end
            "}": begin r.emit = 1'b1; r.kind = K_RBRACE; end
            ",": begin r.emit = 1'b1; r.kind = K_COMMA; end
            ".": begin r.emit = 1'b1; r.kind = K_DOT; end
            "-": begin r.emit = 1'b1; r.kind = K_MINUS; end
            "+": begin r.emit = 1'b1; r.kind = K_PLUS; end
            ";": begin r.emit = 1'b1; r.kind = K_SEMI; end
            "*": begin r.emit = 1'b1; r.kind = K_STAR; end
            "!": begin r.mode = MODE_OP; r.op = OP_BANG; end
            "=": begin r.mode = MODE_OP; r.op = OP_EQUAL; end
            "<": begin r.mode = MODE_OP; r.op = OP_LESS; end
            ">": begin r.mode = MODE_OP; r.op = OP_GREATER; end
            "\"": r.mode = MODE_STRING;
            default:
            begin
                if (is_alpha(c))
                begin
                    r.mode = MODE_IDENT;
                    r.word = 1'b1;
                end
                else if (is_digit(c))
                begin
                    r.mode = MODE_NUMBER;
                end
                else
                begin
                    r.emit = 1'b1;
                    r.kind = K_ERROR;
                    r.err  = E_CHAR;
                end
            end
        endcase
        return r;
    endfunction

    // p holds the first word byte in its top byte
    function automatic logic [KIND_W-1:0] keyword_kind(input logic [8*MAX_KW-1:0] p,
                                                       input logic [2:0] len);
        logic [8*MAX_KW-1:0] words [16];
        logic [2:0]          lens  [16];
        logic [8*MAX_KW-1:0] mask;
        logic [KIND_W-1:0]   k;
        words[0]  = {"and", 24'h0};    lens[0]  = 3'd3;
        words[1]  = {"class", 8'h0};   lens[1]  = 3'd5;
        words[2]  = {"else", 16'h0};   lens[2]  = 3'd4;
        words[3]  = {"false", 8'h0};   lens[3]  = 3'd5;
        words[4]  = {"for", 24'h0};    lens[4]  = 3'd3;
        words[5]  = {"fun", 24'h0};    lens[5]  = 3'd3;
        words[6]  = {"if", 32'h0};     lens[6]  = 3'd2;
        words[7]  = {"nil", 24'h0};    lens[7]  = 3'd3;
        words[8]  = {"or", 32'h0};     lens[8]  = 3'd2;
        words[9]  = {"print", 8'h0};   lens[9]  = 3'd5;
        words[10] = "return";          lens[10] = 3'd6;
        words[11] = {"super", 8'h0};   lens[11] = 3'd5;
        words[12] = {"this", 16'h0};   lens[12] = 3'd4;
        words[13] = {"true", 16'h0};   lens[13] = 3'd4;
        words[14] = {"var", 24'h0};    lens[14] = 3'd3;
        words[15] = {"while", 8'h0};   lens[15] = 3'd5;
        mask = {(8*MAX_KW){1'b1}} << (8 * (MAX_KW - int'(len)));
        k = K_IDENT;
        for (int i = 15; i >= 0; i--)
        begin
            if (len == lens[i] && (p & mask) == words[i])
            begin
                k = KIND_W'(22 + i);
            end
        end
        return k;
    endfunction

endpackage

@@ hdl/script_lexer_byte_stream_top.sv @@
// An accepted byte's tokens go as one group into a four-entry queue of
// per-byte token groups (up to three tokens each). One byte is taken per cycle
// if the queue has room; tokens leave one per cycle while out_ready is high.
// Reset (rst_n, async, active low): idle scanner, offset 0, line 1, queue empty.
module script_lexer_byte_stream_top #(
    parameter int OFFSET_BITS   = slbs_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS     = slbs_pkg::LINE_BITS_DEF,
    parameter int KEYWORD_CHARS = slbs_pkg::KEYWORD_CHARS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_byte,
    input  logic        is_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  token_kind,
    output logic [19:0] start_offset,
    output logic [19:0] token_length,
    output logic [15:0] line_number,
    output logic [1:0]  error_kind,
    output logic        last_of_run
);

    localparam int BW = slbs_pkg::bundle_bits(OFFSET_BITS, LINE_BITS);

    logic          q_ready;
    logic          push;
    logic [BW-1:0] bundle;

    slbs_front #(
        .OFFSET_BITS   (OFFSET_BITS),
        .LINE_BITS     (LINE_BITS),
        .KEYWORD_CHARS (KEYWORD_CHARS),
        .BW            (BW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_byte (char_byte),
        .is_end    (is_end),
        .q_ready   (q_ready),
        .push      (push),
        .bundle    (bundle)
    );

    slbs_back #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS),
        .BW          (BW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .bundle       (bundle),
        .q_ready      (q_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .start_offset (start_offset),
        .token_length (token_length),
        .line_number  (line_number),
        .error_kind   (error_kind),
        .last_of_run  (last_of_run)
    );

endmodule

@@ hdl/slbs_front.sv @@
module slbs_front #(
    parameter int OFFSET_BITS   = slbs_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS     = slbs_pkg::LINE_BITS_DEF,
    parameter int KEYWORD_CHARS = slbs_pkg::KEYWORD_CHARS_DEF,
    parameter int BW            = slbs_pkg::bundle_bits(OFFSET_BITS, LINE_BITS)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    char_byte,
    input  logic          is_end,
    input  logic          q_ready,
    output logic          push,
    output logic [BW-1:0] bundle
);

    localparam int OB = OFFSET_BITS;
    localparam int LB = LINE_BITS;
    localparam int IW = $clog2(KEYWORD_CHARS);

    typedef struct packed {
        logic [slbs_pkg::KIND_W-1:0] kind;
        logic [OB-1:0]               start;
        logic [OB:0]                 len;
        logic [slbs_pkg::ERR_W-1:0]  err;
    } tok_t;

    typedef struct packed {
        logic [1:0]    cnt;
        logic [LB-1:0] line;
        tok_t [2:0]    toks;
    } bundle_t;

    slbs_pkg::mode_t mode_reg, mode_next;
    logic [1:0]      op_reg, op_next;
    logic [OB-1:0]   ts_reg, ts_next;
    logic [OB-1:0]   pos_reg, pos_next;
    logic [LB-1:0]   line_reg, line_next;
    logic            fin_reg, fin_next;
    logic [7:0]      prefix_reg [KEYWORD_CHARS];

    bundle_t                         b;
    slbs_pkg::idle_t                 ib;
    logic                            accept;
    logic                            end_in;
    logic                            again;
    logic                            wr_en;
    logic [IW-1:0]                   wr_idx;
    logic [OB-1:0]                   span_w;
    logic [OB-1:0]                   dot;
    logic [8*slbs_pkg::MAX_KW-1:0]   pv;
    logic [slbs_pkg::KIND_W-1:0]     kw;

    function automatic tok_t mk(input logic [slbs_pkg::KIND_W-1:0] k,
                                input logic [OB-1:0] s, input logic [OB:0] l,
                                input logic [slbs_pkg::ERR_W-1:0] e);
        tok_t t;
        t.kind = k;
        t.start = s;
        t.len = l;
        t.err = e;
        return t;
    endfunction

    assign in_ready = q_ready;
    assign accept   = in_valid && in_ready;
    assign end_in   = is_end || char_byte == 8'h00;
    assign span_w   = pos_reg - ts_reg;
    assign dot      = (pos_reg != '0) ? pos_reg - OB'(1) : '0;
    assign ib       = slbs_pkg::classify(char_byte);

    always_comb
    begin
        for (int i = 0; i < slbs_pkg::MAX_KW; i++)
        begin
            pv[8*(slbs_pkg::MAX_KW-1-i) +: 8] = prefix_reg[i];
        end
    end

    assign kw = slbs_pkg::keyword_kind(pv, (span_w <= OB'(slbs_pkg::MAX_KW)) ?
                                           span_w[2:0] : 3'd7);

    always_comb
    begin
        b         = '0;
        b.line    = line_reg;
        again     = 1'b0;
        mode_next = mode_reg;
        op_next   = op_reg;
        ts_next   = ts_reg;
        pos_next  = pos_reg;
        line_next = line_reg;
        fin_next  = fin_reg;
        wr_en     = 1'b0;
        wr_idx    = span_w[IW-1:0];
        if (fin_reg)
        begin
        end
        else if (end_in)
        begin
            unique case (mode_reg)
                slbs_pkg::MODE_SLASH:
                begin
                    b.toks[0] = mk(slbs_pkg::K_SLASH, ts_reg, (OB+1)'(1), slbs_pkg::E_NONE);
                    b.cnt = 2'd1;
                end
                slbs_pkg::MODE_OP:
                begin
                    b.toks[0] = mk(slbs_pkg::op_kind(op_reg), ts_reg, (OB+1)'(1),
                                   slbs_pkg::E_NONE);
                    b.cnt = 2'd1;
                end
                slbs_pkg::MODE_IDENT:
                begin
                    b.toks[0] = mk(kw, ts_reg, (OB+1)'(span_w), slbs_pkg::E_NONE);
                    b.cnt = 2'd1;
                end
                slbs_pkg::MODE_NUMBER, slbs_pkg::MODE_FRACTION:
                begin
                    b.toks[0] = mk(slbs_pkg::K_NUMBER, ts_reg, (OB+1)'(span_w),
                                   slbs_pkg::E_NONE);
                    b.cnt = 2'd1;
                end
                slbs_pkg::MODE_NUMDOT:
                begin
                    b.toks[0] = mk(slbs_pkg::K_NUMBER, ts_reg,
                                   (dot > ts_reg) ? (OB+1)'(dot - ts_reg) : '0,
                                   slbs_pkg::E_NONE);
                    b.toks[1] = mk(slbs_pkg::K_DOT, dot, (OB+1)'(1), slbs_pkg::E_NONE);
                    b.cnt = 2'd2;
                end
                slbs_pkg::MODE_STRING:
                begin
                    b.toks[0] = mk(slbs_pkg::K_ERROR, ts_reg, (OB+1)'(span_w),
                                   slbs_pkg::E_UNTERM);
                    b.cnt = 2'd1;
                end
                default: ;
            endcase
            b.toks[b.cnt] = mk(slbs_pkg::K_EOF, pos_reg, '0, slbs_pkg::E_NONE);
            b.cnt = b.cnt + 2'd1;
            mode_next = slbs_pkg::MODE_IDLE;
            fin_next = 1'b1;
        end
        else
        begin
            unique case (mode_reg)
                slbs_pkg::MODE_SLASH:
                begin
                    if (char_byte == "/")
                    begin
                        mode_next = slbs_pkg::MODE_COMMENT;
                    end
                    else
                    begin
                        b.toks[0] = mk(slbs_pkg::K_SLASH, ts_reg, (OB+1)'(1),
                                       slbs_pkg::E_NONE);
                        b.cnt = 2'd1;
                        again = 1'b1;
                    end
                end
                slbs_pkg::MODE_COMMENT:
                begin
                    again = (char_byte == 8'h0A);
                end
                slbs_pkg::MODE_OP:
                begin
                    if (char_byte == "=")
                    begin
                        b.toks[0] = mk(slbs_pkg::op_kind(op_reg) + 6'd1, ts_reg,
                                       (OB+1)'(2), slbs_pkg::E_NONE);
                        b.cnt = 2'd1;
                        mode_next = slbs_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        b.toks[0] = mk(slbs_pkg::op_kind(op_reg), ts_reg, (OB+1)'(1),
                                       slbs_pkg::E_NONE);
                        b.cnt = 2'd1;
                        again = 1'b1;
                    end
                end
                slbs_pkg::MODE_IDENT:
                begin
                    if (slbs_pkg::is_alpha(char_byte) || slbs_pkg::is_digit(char_byte))
                    begin
                        wr_en = (span_w < OB'(KEYWORD_CHARS));
                    end
                    else
                    begin
                        b.toks[0] = mk(kw, ts_reg, (OB+1)'(span_w), slbs_pkg::E_NONE);
                        b.cnt = 2'd1;
                        again = 1'b1;
                    end
                end
                slbs_pkg::MODE_NUMBER:
                begin
                    if (char_byte == ".")
                    begin
                        mode_next = slbs_pkg::MODE_NUMDOT;
                    end
                    else if (!slbs_pkg::is_digit(char_byte))
                    begin
                        b.toks[0] = mk(slbs_pkg::K_NUMBER, ts_reg, (OB+1)'(span_w),
                                       slbs_pkg::E_NONE);
                        b.cnt = 2'd1;
                        again = 1'b1;
                    end
                end
                slbs_pkg::MODE_NUMDOT:
                begin
                    if (slbs_pkg::is_digit(char_byte))
                    begin
                        mode_next = slbs_pkg::MODE_FRACTION;
                    end
                    else
                    begin
                        b.toks[0] = mk(slbs_pkg::K_NUMBER, ts_reg,
                                       (dot > ts_reg) ? (OB+1)'(dot - ts_reg) : '0,
                                       slbs_pkg::E_NONE);
                        b.toks[1] = mk(slbs_pkg::K_DOT, dot, (OB+1)'(1),
                                       slbs_pkg::E_NONE);
                        b.cnt = 2'd2;
                        again = 1'b1;
                    end
                end
                slbs_pkg::MODE_FRACTION:
                begin
                    if (!slbs_pkg::is_digit(char_byte))
                    begin
                        b.toks[0] = mk(slbs_pkg::K_NUMBER, ts_reg, (OB+1)'(span_w),
                                       slbs_pkg::E_NONE);
                        b.cnt = 2'd1;
                        again = 1'b1;
                    end
                end
                slbs_pkg::MODE_STRING:
                begin
                    if (char_byte == "\"")
                    begin
                        b.toks[0] = mk(slbs_pkg::K_STRING, ts_reg,
                                       (OB+1)'(span_w) + (OB+1)'(1), slbs_pkg::E_NONE);
                        b.cnt = 2'd1;
                        mode_next = slbs_pkg::MODE_IDLE;
                    end
                    else if (char_byte == 8'h0A && line_reg != '1)
                    begin
                        line_next = line_reg + LB'(1);
                    end
                end
                default: again = 1'b1;
            endcase
            if (again)
            begin
                ts_next = pos_reg;
                mode_next = ib.mode;
                if (ib.mode == slbs_pkg::MODE_OP)
                begin
                    op_next = ib.op;
                end
                if (ib.bump && line_reg != '1)
                begin
                    line_next = line_reg + LB'(1);
                end
                if (ib.word)
                begin
                    wr_en = 1'b1;
                    wr_idx = '0;
                end
                if (ib.emit)
                begin
                    b.toks[b.cnt] = mk(ib.kind, pos_reg, (OB+1)'(1), ib.err);
                    b.cnt = b.cnt + 2'd1;
                end
            end
            if (pos_reg != '1)
            begin
                pos_next = pos_reg + OB'(1);
            end
        end
    end

    assign push   = accept && b.cnt != 2'd0;
    assign bundle = b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= slbs_pkg::MODE_IDLE;
            op_reg   <= '0;
            ts_reg   <= '0;
            pos_reg  <= '0;
            line_reg <= LB'(1);
            fin_reg  <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            op_reg   <= op_next;
            ts_reg   <= ts_next;
            pos_reg  <= pos_next;
            line_reg <= line_next;
            fin_reg  <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && wr_en)
        begin
            prefix_reg[wr_idx] <= char_byte;
        end
    end

endmodule

@@ hdl/slbs_back.sv @@
module slbs_back #(
    parameter int OFFSET_BITS = slbs_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS   = slbs_pkg::LINE_BITS_DEF,
    parameter int BW          = slbs_pkg::bundle_bits(OFFSET_BITS, LINE_BITS)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [BW-1:0] bundle,
    output logic          q_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [5:0]    token_kind,
    output logic [19:0]   start_offset,
    output logic [19:0]   token_length,
    output logic [15:0]   line_number,
    output logic [1:0]    error_kind,
    output logic          last_of_run
);

    localparam int OB = OFFSET_BITS;
    localparam int LB = LINE_BITS;

    typedef struct packed {
        logic [slbs_pkg::KIND_W-1:0] kind;
        logic [OB-1:0]               start;
        logic [OB:0]                 len;
        logic [slbs_pkg::ERR_W-1:0]  err;
    } tok_t;

    typedef struct packed {
        logic [1:0]    cnt;
        logic [LB-1:0] line;
        tok_t [2:0]    toks;
    } bundle_t;

    bundle_t    q_mem [4];
    logic [1:0] wp_reg, rp_reg, sel_reg;
    logic [2:0] count_reg;
    bundle_t    head;
    tok_t       t;
    logic       pop_tok, pop_b;
    logic [32:0] s_w, l_w, n_w;

    assign q_ready   = count_reg != 3'd4;
    assign out_valid = count_reg != 3'd0;
    assign head      = q_mem[rp_reg];
    assign t         = head.toks[sel_reg];
    assign last_of_run = (sel_reg == head.cnt - 2'd1);
    assign pop_tok   = out_valid && out_ready;
    assign pop_b     = pop_tok && last_of_run;

    assign s_w = 33'(t.start);
    assign l_w = 33'(t.len);
    assign n_w = 33'(head.line);
    assign token_kind   = t.kind;
    assign error_kind   = t.err;
    assign start_offset = (s_w > 33'hFFFFF) ? 20'hFFFFF : s_w[19:0];
    assign token_length = (l_w > 33'hFFFFF) ? 20'hFFFFF : l_w[19:0];
    assign line_number  = (n_w > 33'hFFFF) ? 16'hFFFF : n_w[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            sel_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 2'd1;
            end
            if (pop_tok)
            begin
                sel_reg <= pop_b ? 2'd0 : sel_reg + 2'd1;
            end
            if (pop_b)
            begin
                rp_reg <= rp_reg + 2'd1;
            end
            count_reg <= count_reg + {2'b0, push} - {2'b0, pop_b};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wp_reg] <= bundle;
        end
    end

endmodule
